// ===== hw/rtl/fcpc_pkg.sv =====
package fcpc_pkg;

   localparam int TEMP_W   = 10;
   localparam int DUTY_W   = 16;
   localparam int PERIOD_W = 16;
   localparam int POINT_W  = 26;
   localparam int COUNT_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CMP_W    = 16;

   // |(t - t1) * (d2 - d1)| < 1024 * 32768, quotient <= 32768
   localparam int NUM_W = 25;
   localparam int DEN_W = 10;
   localparam int QUO_W = 17;

   localparam logic [DUTY_W-1:0] FULL_DUTY = 16'h8000;
   localparam logic [CMP_W-1:0]  CMP_MAX   = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_0      = 3'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SUM,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic resolve;
      logic mult;
      logic div_start;
      logic sum;
      logic scale;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic need_div;
      logic div_done;
   } status_type;

   function automatic logic signed [TEMP_W-1:0] pt_temp(input logic [POINT_W-1:0] p);
      return $signed(p[POINT_W-1:DUTY_W]);
   endfunction

   // duty above full scale reads as full scale
   function automatic logic [DUTY_W-1:0] pt_duty(input logic [POINT_W-1:0] p);
      return (p[DUTY_W-1:0] > FULL_DUTY) ? FULL_DUTY : p[DUTY_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/fcpc_div.sv =====
module fcpc_div
   import fcpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   // one quotient bit a cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== hw/rtl/fcpc_datapath.sv =====
module fcpc_datapath
   import fcpc_pkg::*;
#(
   parameter int MAX_POINTS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [POINT_W-1:0]       csr_data,
   output logic [CMP_W-1:0]         rsp_compare_value,
   output logic [DUTY_W-1:0]        rsp_duty_level,
   output logic                     rsp_fell_back
);

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int KW = $clog2(MAX_POINTS + 1);

   // configuration
   logic [COUNT_W-1:0]  count_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [POINT_W-1:0]  point_ff [MAX_POINTS];
   logic [CSR_IDX_W-1:0] pidx;
   logic                 pt_we;

   assign pidx  = csr_index - CSR_POINT_0;
   assign pt_we = csr_write_enable && (csr_index >= CSR_POINT_0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_W'(1);
         period_ff <= '0;
         for (int j = 0; j < MAX_POINTS; j++) begin
            point_ff[j] <= '0;
         end
      end else begin
         if (csr_write_enable && csr_index == CSR_POINT_COUNT) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end
         if (csr_write_enable && csr_index == CSR_TIMER_PERIOD) begin
            period_ff <= csr_data[PERIOD_W-1:0];
         end
         for (int j = 0; j < MAX_POINTS; j++) begin
            if (pt_we && pidx == CSR_IDX_W'(j)) begin
               point_ff[j] <= csr_data;
            end
         end
      end
   end

   // last breakpoint in use
   logic [KW-1:0] last_idx;

   always_comb begin
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (int'(count_ff) > MAX_POINTS) begin
         last_idx = KW'(MAX_POINTS - 1);
      end else begin
         last_idx = KW'(count_ff - 1'b1);
      end
   end

   // working registers
   logic signed [TEMP_W-1:0] temp_ff, prev_t_ff, t1_ff, t2_ff;
   logic [DUTY_W-1:0]        prev_d_ff, first_d_ff, d1_ff, d2_ff;
   logic                     below_ff, found_ff;
   logic [KW-1:0]            k_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]         den_ff;
   logic                     neg_ff;
   logic [DUTY_W-1:0]        duty_ff;
   logic                     fb_ff;
   logic [CMP_W-1:0]         cmp_ff;

   logic [POINT_W-1:0]       cur_pt;
   logic signed [TEMP_W-1:0] cur_t;
   logic [DUTY_W-1:0]        cur_d;
   logic                     above;

   assign cur_pt = point_ff[k_ff[IW-1:0]];
   assign cur_t  = pt_temp(cur_pt);
   assign cur_d  = pt_duty(cur_pt);
   // once the scan ends, the previous point is the last one in use
   assign above  = (temp_ff >= prev_t_ff);

   // interpolation arithmetic
   logic signed [TEMP_W:0]   dt;
   logic signed [DUTY_W:0]   dd;
   logic signed [TEMP_W+DUTY_W+1:0] prod;
   logic [TEMP_W+DUTY_W+1:0] mag;
   logic [TEMP_W:0]          span;
   logic                     div_done;
   logic [NUM_W-1:0]         quo;
   logic signed [DUTY_W+1:0] qs, sum;
   logic [DUTY_W:0]          mean;
   logic [DUTY_W+PERIOD_W-1:0] scaled;
   logic [DUTY_W+PERIOD_W-16:0] shifted;

   assign dt   = {temp_ff[TEMP_W-1], temp_ff} - {t1_ff[TEMP_W-1], t1_ff};
   assign dd   = {1'b0, d2_ff} - {1'b0, d1_ff};
   assign prod = dt * dd;
   assign mag  = prod[TEMP_W+DUTY_W+1] ? -prod : prod;
   assign span = {t2_ff[TEMP_W-1], t2_ff} - {t1_ff[TEMP_W-1], t1_ff};
   assign mean = ({1'b0, d1_ff} + {1'b0, d2_ff}) >> 1;
   assign qs   = neg_ff ? -$signed({1'b0, quo[QUO_W-1:0]})
                        : $signed({1'b0, quo[QUO_W-1:0]});
   assign sum  = $signed({2'b00, d1_ff}) + qs;
   assign scaled  = duty_ff * period_ff;
   assign shifted = scaled[DUTY_W+PERIOD_W-1:15];

   fcpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_ff    <= req_temperature;
         prev_t_ff  <= pt_temp(point_ff[0]);
         prev_d_ff  <= pt_duty(point_ff[0]);
         first_d_ff <= pt_duty(point_ff[0]);
         below_ff   <= (req_temperature <= pt_temp(point_ff[0]));
         found_ff   <= 1'b0;
         k_ff       <= KW'(1);
      end
      if (cmd.step) begin
         // keep the first segment that holds the sample
         if (!found_ff && temp_ff >= prev_t_ff && temp_ff <= cur_t) begin
            found_ff <= 1'b1;
            t1_ff    <= prev_t_ff;
            d1_ff    <= prev_d_ff;
            t2_ff    <= cur_t;
            d2_ff    <= cur_d;
         end
         prev_t_ff <= cur_t;
         prev_d_ff <= cur_d;
         k_ff      <= k_ff + 1'b1;
      end
      if (cmd.resolve) begin
         fb_ff <= 1'b0;
         priority if (below_ff) begin
            duty_ff <= first_d_ff;
         end else if (above) begin
            duty_ff <= prev_d_ff;
         end else if (found_ff) begin
            duty_ff <= mean[DUTY_W-1:0];
         end else begin
            duty_ff <= FULL_DUTY;
            fb_ff   <= 1'b1;
         end
      end
      if (cmd.mult) begin
         num_ff <= mag[NUM_W-1:0];
         neg_ff <= prod[TEMP_W+DUTY_W+1];
         den_ff <= span[DEN_W-1:0];
      end
      if (cmd.sum) begin
         priority if (sum < 0) begin
            duty_ff <= '0;
         end else if (sum > $signed({2'b00, FULL_DUTY})) begin
            duty_ff <= FULL_DUTY;
         end else begin
            duty_ff <= sum[DUTY_W-1:0];
         end
      end
      if (cmd.scale) begin
         cmp_ff <= (shifted > {1'b0, CMP_MAX}) ? CMP_MAX : shifted[CMP_W-1:0];
      end
   end

   assign status.scan_done = (k_ff > last_idx);
   assign status.need_div  = !below_ff && !above && found_ff && (t1_ff != t2_ff);
   assign status.div_done  = div_done;

   assign rsp_compare_value = cmp_ff;
   assign rsp_duty_level    = duty_ff;
   assign rsp_fell_back     = fb_ff;

endmodule

// ===== hw/rtl/fcpc_ctrl.sv =====
module fcpc_ctrl
   import fcpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_strobe
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               cmd.resolve = 1'b1;
               state_in    = status.need_div ? ST_MULT : ST_SCALE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fan_curve_pwm_compare.sv =====
// channel   ports                                   handshake
// request   req_temperature                         start, taken while busy is low
// response  rsp_compare_value, rsp_duty_level,      rsp_strobe, one cycle, no stall
//           rsp_fell_back
// config    csr_index, csr_data                     csr_write_enable, taken at once
//
// A word runs scan, scale and strobe when the sample clamps, falls back or lands on a
// zero-width segment; interpolation adds mult, divide and sum before scale; the 25-step
// divider makes it the long case. The segment scan reads one breakpoint a cycle.
// Busy stays high until the strobe cycle ends; the next word is taken after that.
// Reset is synchronous and returns the curve registers to their defaults.
module fan_curve_pwm_compare
   import fcpc_pkg::*;
#(
   parameter int MAX_POINTS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [TEMP_W-1:0] req_temperature,
   output logic                     rsp_strobe,
   output logic [CMP_W-1:0]         rsp_compare_value,
   output logic [DUTY_W-1:0]        rsp_duty_level,
   output logic                     rsp_fell_back,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [POINT_W-1:0]       csr_data
);

   cmd_type    cmd;
   status_type status;

   fcpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   fcpc_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_temperature   (req_temperature),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_compare_value (rsp_compare_value),
      .rsp_duty_level    (rsp_duty_level),
      .rsp_fell_back     (rsp_fell_back)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a word in flight");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_duty_level <= FULL_DUTY))
      else $error("duty above full scale");

   a_fallback_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fell_back) |-> (rsp_duty_level == FULL_DUTY))
      else $error("fallback without full duty");
`endif

endmodule
